// ===== rtl/core/c8core_pkg.sv =====
// shared types and constants for the chip-8 instruction core
// no dependencies; used by the alu, the instruction core and the checker
`default_nettype none
package c8core_pkg;

   localparam int MEM_BYTES_DEF     = 4096;
   localparam int STACK_DEPTH_DEF   = 16;
   localparam int SCREEN_WIDTH_DEF  = 64;
   localparam int SCREEN_HEIGHT_DEF = 32;

   localparam logic [11:0] PC_RESET  = 12'h200;
   localparam logic [15:0] FONT_BASE = 16'h0050;

   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_CLEAR   = 2'd1;
   localparam logic [1:0] EV_DRAW    = 2'd2;
   localparam logic [1:0] EV_INVALID = 2'd3;

   localparam logic [15:0] INS_CLS = 16'h00E0;
   localparam logic [15:0] INS_RET = 16'h00EE;
   localparam logic [7:0]  NN_SKP  = 8'h9E;
   localparam logic [7:0]  NN_SKNP = 8'hA1;
   localparam logic [7:0]  NN_GDT  = 8'h07;
   localparam logic [7:0]  NN_KEY  = 8'h0A;
   localparam logic [7:0]  NN_SDT  = 8'h15;
   localparam logic [7:0]  NN_SST  = 8'h18;
   localparam logic [7:0]  NN_ADDI = 8'h1E;
   localparam logic [7:0]  NN_FONT = 8'h29;
   localparam logic [7:0]  NN_BCD  = 8'h33;
   localparam logic [7:0]  NN_STR  = 8'h55;
   localparam logic [7:0]  NN_LDR  = 8'h65;

   localparam logic [3:0] OP_SYS  = 4'h0;
   localparam logic [3:0] OP_JP   = 4'h1;
   localparam logic [3:0] OP_CALL = 4'h2;
   localparam logic [3:0] OP_SE   = 4'h3;
   localparam logic [3:0] OP_SNE  = 4'h4;
   localparam logic [3:0] OP_SER  = 4'h5;
   localparam logic [3:0] OP_LD   = 4'h6;
   localparam logic [3:0] OP_ADD  = 4'h7;
   localparam logic [3:0] OP_ALU  = 4'h8;
   localparam logic [3:0] OP_SNER = 4'h9;
   localparam logic [3:0] OP_LDI  = 4'hA;
   localparam logic [3:0] OP_JPV  = 4'hB;
   localparam logic [3:0] OP_RND  = 4'hC;
   localparam logic [3:0] OP_DRW  = 4'hD;
   localparam logic [3:0] OP_KEY  = 4'hE;

   localparam logic [3:0] N_MOV = 4'h0;
   localparam logic [3:0] N_OR  = 4'h1;
   localparam logic [3:0] N_AND = 4'h2;
   localparam logic [3:0] N_XOR = 4'h3;
   localparam logic [3:0] N_ADD = 4'h4;
   localparam logic [3:0] N_SUB = 4'h5;
   localparam logic [3:0] N_SHR = 4'h6;
   localparam logic [3:0] N_SBN = 4'h7;
   localparam logic [3:0] N_SHL = 4'hE;

   typedef enum logic [2:0] {
      ALU_ADD, ALU_SUB, ALU_OR, ALU_AND, ALU_XOR, ALU_SHR, ALU_SHL
   } alu_op_type;

   typedef struct packed {
      alu_op_type  op;
      logic [15:0] a;
      logic [15:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [15:0] res;
      logic        flag;
      logic        zero;
   } alu_rsp_type;

endpackage
`default_nettype wire

// ===== rtl/core/c8core_ram.sv =====
// generic single-write, single-read memory with registered read data
// no dependencies; used for program memory and the return stack
`default_nettype none
module c8core_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/c8core_alu.sv =====
// shared arithmetic, logic and compare unit of the core
// depends on c8core_pkg
`default_nettype none
module c8core_alu
   import c8core_pkg::*;
(
   input  wire alu_req_type req,
   output alu_rsp_type      rsp
);

   logic [16:0] sum;
   logic [16:0] diff;

   always_comb begin
      sum  = {1'b0, req.a} + {1'b0, req.b};
      diff = {1'b0, req.a} - {1'b0, req.b};
      rsp.res  = 16'd0;
      rsp.flag = 1'b0;
      case (req.op)
         ALU_ADD: begin
            rsp.res  = sum[15:0];
            rsp.flag = sum[8];
         end
         ALU_SUB: begin
            rsp.res  = diff[15:0];
            rsp.flag = ~diff[16];
         end
         ALU_OR:  rsp.res = req.a | req.b;
         ALU_AND: rsp.res = req.a & req.b;
         ALU_XOR: rsp.res = req.a ^ req.b;
         ALU_SHR: begin
            rsp.res  = {9'd0, req.a[7:1]};
            rsp.flag = req.a[0];
         end
         ALU_SHL: begin
            rsp.res  = {8'd0, req.a[6:0], 1'b0};
            rsp.flag = req.a[7];
         end
         default: rsp.res = 16'd0;
      endcase
      rsp.zero = (diff[15:0] == 16'd0);
   end

endmodule
`default_nettype wire

// ===== rtl/core/chip8_instruction_core.sv =====
// chip-8 instruction core: sequencer, register file and delay timer
// depends on c8core_pkg, c8core_ram and c8core_alu
//
// usage:
//   an item is taken when start is high and busy is low. req_func = 0
//   writes req_load_data to memory at req_load_addr; req_func = 1 fetches
//   the instruction at the program counter and executes it, using req_keys
//   and req_random_byte as sampled at that edge.
//   every item gives exactly one result, shown for one cycle with
//   rsp_valid high; the receiver cannot stall it. rsp_next_pc always holds
//   the program counter after the item; draw fields are zero unless
//   rsp_event_res reports a draw.
//   a load writes memory and goes straight to the result; a plain
//   instruction takes two memory reads for the fetch, two register reads,
//   execute and result. draws add modulo steps for x and y, bcd stores add
//   subtraction steps and the writes, Fx55 a store step per register and
//   Fx65 a read and a writeback step per register, plus a step to update i,
//   all through the one shared alu. busy falls in the cycle the result is shown.
//   reset clears registers, index, stack pointer and timer, sets the
//   program counter to 0x200; memory and stack contents are undefined
//   until written.
`default_nettype none
module chip8_instruction_core
   import c8core_pkg::*;
#(
   parameter int MEM_BYTES     = MEM_BYTES_DEF,
   parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_func,
   input  wire logic [11:0] req_load_addr,
   input  wire logic [7:0]  req_load_data,
   input  wire logic [15:0] req_keys,
   input  wire logic [7:0]  req_random_byte,
   output logic             rsp_valid,
   output logic [1:0]       rsp_event_res,
   output logic [5:0]       rsp_draw_x,
   output logic [4:0]       rsp_draw_y,
   output logic [3:0]       rsp_sprite_rows,
   output logic [15:0]      rsp_sprite_addr,
   output logic [11:0]      rsp_next_pc
);

   localparam int MEM_AW = $clog2(MEM_BYTES);
   localparam int SP_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_FETCH_HI = 5'd1;
   localparam logic [4:0] S_FETCH_LO = 5'd2;
   localparam logic [4:0] S_READ_X   = 5'd3;
   localparam logic [4:0] S_READ_Y   = 5'd4;
   localparam logic [4:0] S_EXEC     = 5'd5;
   localparam logic [4:0] S_FLAG     = 5'd6;
   localparam logic [4:0] S_MOD_X    = 5'd7;
   localparam logic [4:0] S_MOD_Y    = 5'd8;
   localparam logic [4:0] S_BCD_H    = 5'd9;
   localparam logic [4:0] S_BCD_T    = 5'd10;
   localparam logic [4:0] S_BCD_W0   = 5'd11;
   localparam logic [4:0] S_BCD_W1   = 5'd12;
   localparam logic [4:0] S_BCD_W2   = 5'd13;
   localparam logic [4:0] S_XFER_ST  = 5'd14;
   localparam logic [4:0] S_XFER_RD  = 5'd15;
   localparam logic [4:0] S_XFER_WB  = 5'd16;
   localparam logic [4:0] S_IADD     = 5'd17;
   localparam logic [4:0] S_DONE     = 5'd18;

   logic [4:0]  state_ff, state_in;
   logic [11:0] pc_ff, pc_in;
   logic [11:0] here_ff, here_in;
   logic [15:0] i_ff, i_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [7:0]  dt_ff, dt_in;
   logic [7:0]  regs_ff [16];
   logic [15:0] ins_ff, ins_in;
   logic [15:0] keys_ff, keys_in;
   logic [7:0]  rnd_ff, rnd_in;
   logic [7:0]  vx_ff, vx_in;
   logic [7:0]  vy_ff, vy_in;
   logic        flag_ff, flag_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [7:0]  rem_ff, rem_in;
   logic [3:0]  hund_ff, hund_in;
   logic [3:0]  tens_ff, tens_in;
   logic [1:0]  ev_ff, ev_in;
   logic [5:0]  dx_ff, dx_in;
   logic [4:0]  dy_ff, dy_in;
   logic [3:0]  rows_ff, rows_in;
   logic [15:0] saddr_ff, saddr_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        regs_we;
   logic [3:0]  regs_wa;
   logic [7:0]  regs_wd;
   logic [3:0]  regs_ra;
   logic [7:0]  regs_rd;

   logic              mem_we;
   logic [MEM_AW-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic [MEM_AW-1:0] mem_raddr;
   logic [7:0]        mem_rdata;

   logic            stk_we;
   logic [SP_W-1:0] stk_raddr;
   logic [11:0]     stk_rdata;
   logic [SP_W-1:0] sp_inc;
   logic [SP_W-1:0] sp_dec;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic [3:0] op;
   logic [3:0] xi;
   logic [3:0] yi;
   logic [3:0] ni;
   logic [7:0] nn;
   logic [11:0] nnn;
   logic       key_dn;
   logic [11:0] pc_skip;

   c8core_ram #(.DEPTH(MEM_BYTES), .WIDTH(8)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   c8core_ram #(.DEPTH(STACK_DEPTH), .WIDTH(12)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (sp_ff),
      .wr_data (pc_ff),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   c8core_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign op      = ins_ff[15:12];
   assign xi      = ins_ff[11:8];
   assign yi      = ins_ff[7:4];
   assign ni      = ins_ff[3:0];
   assign nn      = ins_ff[7:0];
   assign nnn     = ins_ff[11:0];
   assign regs_rd = regs_ff[regs_ra];
   assign key_dn  = keys_ff[vx_ff[3:0]];
   assign pc_skip = pc_ff + 12'd2;
   assign sp_inc  = (sp_ff == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_ff + SP_W'(1);
   assign sp_dec  = (sp_ff == '0) ? SP_W'(STACK_DEPTH - 1) : sp_ff - SP_W'(1);
   assign stk_raddr = sp_dec;

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      here_in      = here_ff;
      i_in         = i_ff;
      sp_in        = sp_ff;
      dt_in        = dt_ff;
      ins_in       = ins_ff;
      keys_in      = keys_ff;
      rnd_in       = rnd_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      flag_in      = flag_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      hund_in      = hund_ff;
      tens_in      = tens_ff;
      ev_in        = ev_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      rows_in      = rows_ff;
      saddr_in     = saddr_ff;
      rsp_valid_in = 1'b0;
      regs_we      = 1'b0;
      regs_wa      = xi;
      regs_wd      = 8'd0;
      regs_ra      = xi;
      mem_we       = 1'b0;
      mem_waddr    = MEM_AW'(req_load_addr);
      mem_wdata    = req_load_data;
      mem_raddr    = MEM_AW'(pc_ff);
      stk_we       = 1'b0;
      alu_req.op   = ALU_ADD;
      alu_req.a    = {8'd0, vx_ff};
      alu_req.b    = {8'd0, vy_ff};

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ev_in    = EV_NONE;
               dx_in    = 6'd0;
               dy_in    = 5'd0;
               rows_in  = 4'd0;
               saddr_in = 16'd0;
               keys_in  = req_keys;
               rnd_in   = req_random_byte;
               if (req_func) begin
                  state_in = S_FETCH_HI;
               end else begin
                  mem_we   = 1'b1;
                  state_in = S_DONE;
               end
            end
         end
         S_FETCH_HI: begin
            ins_in[15:8] = mem_rdata;
            mem_raddr    = MEM_AW'(pc_ff + 12'd1);
            state_in     = S_FETCH_LO;
         end
         S_FETCH_LO: begin
            ins_in[7:0] = mem_rdata;
            here_in     = pc_ff;
            pc_in       = pc_skip;
            state_in    = S_READ_X;
         end
         S_READ_X: begin
            vx_in    = regs_rd;
            state_in = S_READ_Y;
         end
         S_READ_Y: begin
            regs_ra  = yi;
            vy_in    = regs_rd;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (op)
               OP_SYS: begin
                  if (ins_ff == INS_CLS) begin
                     ev_in = EV_CLEAR;
                  end else if (ins_ff == INS_RET) begin
                     sp_in = sp_dec;
                     pc_in = stk_rdata;
                  end else begin
                     ev_in = EV_INVALID;
                  end
               end
               OP_JP: pc_in = nnn;
               OP_CALL: begin
                  stk_we = 1'b1;
                  sp_in  = sp_inc;
                  pc_in  = nnn;
               end
               OP_SE, OP_SNE: begin
                  alu_req.op = ALU_SUB;
                  alu_req.b  = {8'd0, nn};
                  if (alu_rsp.zero == (op == OP_SE)) begin
                     pc_in = pc_skip;
                  end
               end
               OP_SER, OP_SNER: begin
                  alu_req.op = ALU_SUB;
                  if (alu_rsp.zero == (op == OP_SER)) begin
                     pc_in = pc_skip;
                  end
               end
               OP_LD: begin
                  regs_we = 1'b1;
                  regs_wd = nn;
               end
               OP_ADD: begin
                  alu_req.b = {8'd0, nn};
                  regs_we   = 1'b1;
                  regs_wd   = alu_rsp.res[7:0];
               end
               OP_ALU: begin
                  state_in = S_FLAG;
                  regs_we  = 1'b1;
                  case (ni)
                     N_MOV: begin
                        regs_wd  = vy_ff;
                        state_in = S_DONE;
                     end
                     N_OR:  alu_req.op = ALU_OR;
                     N_AND: alu_req.op = ALU_AND;
                     N_XOR: alu_req.op = ALU_XOR;
                     N_ADD: alu_req.op = ALU_ADD;
                     N_SUB: alu_req.op = ALU_SUB;
                     N_SBN: begin
                        alu_req.op = ALU_SUB;
                        alu_req.a  = {8'd0, vy_ff};
                        alu_req.b  = {8'd0, vx_ff};
                     end
                     N_SHR: begin
                        alu_req.op = ALU_SHR;
                        alu_req.a  = {8'd0, vy_ff};
                     end
                     N_SHL: begin
                        alu_req.op = ALU_SHL;
                        alu_req.a  = {8'd0, vy_ff};
                     end
                     default: begin
                        regs_we  = 1'b0;
                        ev_in    = EV_INVALID;
                        state_in = S_DONE;
                     end
                  endcase
                  if (ni != N_MOV) begin
                     regs_wd = alu_rsp.res[7:0];
                  end
                  flag_in = alu_rsp.flag;
               end
               OP_LDI: i_in = {4'd0, nnn};
               OP_JPV: begin
                  alu_req.a = {4'd0, nnn};
                  alu_req.b = {8'd0, regs_ff[0]};
                  pc_in     = alu_rsp.res[11:0];
               end
               OP_RND: begin
                  regs_we = 1'b1;
                  regs_wd = rnd_ff & nn;
               end
               OP_DRW: begin
                  ev_in    = EV_DRAW;
                  rows_in  = ni;
                  saddr_in = i_ff;
                  rem_in   = vx_ff;
                  state_in = S_MOD_X;
               end
               OP_KEY: begin
                  if (nn == NN_SKP) begin
                     if (key_dn) begin
                        pc_in = pc_skip;
                     end
                  end else if (nn == NN_SKNP) begin
                     if (!key_dn) begin
                        pc_in = pc_skip;
                     end
                  end else begin
                     ev_in = EV_INVALID;
                  end
               end
               default: begin
                  case (nn)
                     NN_GDT: begin
                        regs_we = 1'b1;
                        regs_wd = dt_ff;
                     end
                     NN_KEY: begin
                        if (!key_dn) begin
                           pc_in = here_ff;
                        end
                     end
                     NN_SDT: dt_in = vx_ff;
                     NN_SST: ev_in = EV_NONE;
                     NN_ADDI: begin
                        alu_req.a = i_ff;
                        alu_req.b = {8'd0, vx_ff};
                        i_in      = alu_rsp.res;
                     end
                     NN_FONT: i_in = FONT_BASE + 16'(vx_ff) * 16'd5;
                     NN_BCD: begin
                        rem_in   = vx_ff;
                        hund_in  = 4'd0;
                        tens_in  = 4'd0;
                        state_in = S_BCD_H;
                     end
                     NN_STR: begin
                        cnt_in   = 4'd0;
                        state_in = S_XFER_ST;
                     end
                     NN_LDR: begin
                        cnt_in   = 4'd0;
                        state_in = S_XFER_RD;
                     end
                     default: ev_in = EV_INVALID;
                  endcase
               end
            endcase
         end
         S_FLAG: begin
            regs_we  = 1'b1;
            regs_wa  = 4'hF;
            regs_wd  = {7'd0, flag_ff};
            state_in = S_DONE;
         end
         S_MOD_X: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {8'd0, rem_ff};
            alu_req.b  = 16'(SCREEN_WIDTH);
            if (alu_rsp.flag) begin
               rem_in = alu_rsp.res[7:0];
            end else begin
               dx_in    = rem_ff[5:0];
               rem_in   = vy_ff;
               state_in = S_MOD_Y;
            end
         end
         S_MOD_Y: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {8'd0, rem_ff};
            alu_req.b  = 16'(SCREEN_HEIGHT);
            if (alu_rsp.flag) begin
               rem_in = alu_rsp.res[7:0];
            end else begin
               dy_in    = rem_ff[4:0];
               state_in = S_DONE;
            end
         end
         S_BCD_H: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {8'd0, rem_ff};
            alu_req.b  = 16'd100;
            if (alu_rsp.flag) begin
               rem_in  = alu_rsp.res[7:0];
               hund_in = hund_ff + 4'd1;
            end else begin
               state_in = S_BCD_T;
            end
         end
         S_BCD_T: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {8'd0, rem_ff};
            alu_req.b  = 16'd10;
            if (alu_rsp.flag) begin
               rem_in  = alu_rsp.res[7:0];
               tens_in = tens_ff + 4'd1;
            end else begin
               state_in = S_BCD_W0;
            end
         end
         S_BCD_W0: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff[MEM_AW-1:0];
            mem_wdata = {4'd0, hund_ff};
            state_in  = S_BCD_W1;
         end
         S_BCD_W1: begin
            alu_req.a = i_ff;
            alu_req.b = 16'd1;
            mem_we    = 1'b1;
            mem_waddr = alu_rsp.res[MEM_AW-1:0];
            mem_wdata = {4'd0, tens_ff};
            state_in  = S_BCD_W2;
         end
         S_BCD_W2: begin
            alu_req.a = i_ff;
            alu_req.b = 16'd2;
            mem_we    = 1'b1;
            mem_waddr = alu_rsp.res[MEM_AW-1:0];
            mem_wdata = rem_ff;
            state_in  = S_DONE;
         end
         S_XFER_ST: begin
            alu_req.a = i_ff;
            alu_req.b = {12'd0, cnt_ff};
            regs_ra   = cnt_ff;
            mem_we    = 1'b1;
            mem_waddr = alu_rsp.res[MEM_AW-1:0];
            mem_wdata = regs_rd;
            cnt_in    = cnt_ff + 4'd1;
            if (cnt_ff == xi) begin
               state_in = S_IADD;
            end
         end
         S_XFER_RD: begin
            alu_req.a = i_ff;
            alu_req.b = {12'd0, cnt_ff};
            mem_raddr = alu_rsp.res[MEM_AW-1:0];
            state_in  = S_XFER_WB;
         end
         S_XFER_WB: begin
            regs_we = 1'b1;
            regs_wa = cnt_ff;
            regs_wd = mem_rdata;
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == xi) begin
               state_in = S_IADD;
            end else begin
               state_in = S_XFER_RD;
            end
         end
         S_IADD: begin
            alu_req.a = i_ff;
            alu_req.b = {12'd0, xi} + 16'd1;
            i_in      = alu_rsp.res;
            state_in  = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= PC_RESET;
         i_ff         <= 16'd0;
         sp_ff        <= '0;
         dt_ff        <= 8'd0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 16; k++) begin
            regs_ff[k] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         i_ff         <= i_in;
         sp_ff        <= sp_in;
         dt_ff        <= dt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (regs_we) begin
            regs_ff[regs_wa] <= regs_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      here_ff  <= here_in;
      ins_ff   <= ins_in;
      keys_ff  <= keys_in;
      rnd_ff   <= rnd_in;
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      flag_ff  <= flag_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      hund_ff  <= hund_in;
      tens_ff  <= tens_in;
      ev_ff    <= ev_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      rows_ff  <= rows_in;
      saddr_ff <= saddr_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = ev_ff;
   assign rsp_draw_x      = dx_ff;
   assign rsp_draw_y      = dy_ff;
   assign rsp_sprite_rows = rows_ff;
   assign rsp_sprite_addr = saddr_ff;
   assign rsp_next_pc     = pc_ff;

endmodule
`default_nettype wire

// ===== rtl/core/c8core_checker.sv =====
// port-level checks for the chip-8 instruction core, bound into chip8_instruction_core
// depends on c8core_pkg and chip8_instruction_core
`default_nettype none
module c8core_checker
   import c8core_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [1:0]  rsp_event_res,
   input wire logic [5:0]  rsp_draw_x,
   input wire logic [15:0] rsp_sprite_addr
);

   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_take: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("item accepted without going busy");

   a_idle_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("item finished without a result");

   a_nodraw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_DRAW |-> rsp_draw_x == 6'd0 && rsp_sprite_addr == 16'd0)
      else $error("draw fields set on a non-draw result");

endmodule

bind chip8_instruction_core c8core_checker u_c8core_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_event_res   (rsp_event_res),
   .rsp_draw_x      (rsp_draw_x),
   .rsp_sprite_addr (rsp_sprite_addr)
);
`default_nettype wire
